@@ rtl/core/distance_vector_route_table_assert.svh @@
// Assertion macros for the checker file of the route table.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define DVRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define DVRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/dvrt_pkg.sv @@
package dvrt_pkg;

    // Request modes.
    localparam logic [1:0] MODE_HELLO = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;

    // Result status codes.
    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOROUTE   = 3'd5;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_NODE_ID  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BROADCAST_ID = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic resolve;
    } dp_cmd_t;

    // Search status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic miss;
    } dp_stat_t;

endpackage

@@ rtl/core/dvrt_req_if.sv @@
interface dvrt_req_if #(
    parameter int NODE_W = 16,
    parameter int COST_W = 32
);
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [NODE_W-1:0] neighbor_id;
    logic [NODE_W-1:0] target_id;
    logic [COST_W-1:0] advertised_cost;
    logic [COST_W-1:0] link_cost;

    modport source (
        output valid, mode, neighbor_id, target_id, advertised_cost, link_cost,
        input  ready
    );

    modport sink (
        input  valid, mode, neighbor_id, target_id, advertised_cost, link_cost,
        output ready
    );
endinterface

@@ rtl/core/dvrt_rsp_if.sv @@
interface dvrt_rsp_if #(
    parameter int NODE_W = 16,
    parameter int COST_W = 32
);
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [NODE_W-1:0] next_hop;
    logic [COST_W-1:0] route_cost;
    logic              advert_request;

    modport source (
        output valid, status, next_hop, route_cost, advert_request,
        input  ready
    );

    modport sink (
        input  valid, status, next_hop, route_cost, advert_request,
        output ready
    );
endinterface

@@ rtl/core/distance_vector_route_table.sv @@
// A hit ends the search at the matching entry, and a miss compares every entry in the table.
// Only one request is taken at a time. The search reads one entry per cycle, then the resolve
// state does the read-modify-write, which is held while a response stalls.
// Reset: rst_n clears the table to the single self entry (node 0, cost 0), sets the broadcast
// address to all ones and empties the response register. No clearing pass is needed.
module distance_vector_route_table #(
    parameter int TABLE_DEPTH   = 64,
    parameter int NODE_ID_WIDTH = 16,
    parameter int COST_WIDTH    = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dvrt_req_if.sink                         req,
    dvrt_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [dvrt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [NODE_ID_WIDTH-1:0]         cfg_wdata
);
    import dvrt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int RAM_W = 2 * NODE_ID_WIDTH + COST_WIDTH;

    // The controller sequences load, search and resolve; the datapath owns
    // the table state and the compare logic. They talk only through these.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Route RAM port. Each word packs destination, next hop and cost.
    // Entry zero is the node itself and is kept in flops inside the datapath,
    // so RAM word zero is never written or used.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [RAM_W-1:0] ram_rdata;

    dvrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath registers the request, computes the saturated path cost
    // on acceptance, and then compares one stored destination per cycle.
    // The first match wins, which gives the lowest matching entry. The
    // response register is loaded in the resolve cycle, so a new request can
    // be accepted while the previous response still waits downstream.
    dvrt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NODE_W      (NODE_ID_WIDTH),
        .COST_W      (COST_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_mode      (req.mode),
        .in_neighbor  (req.neighbor_id),
        .in_target    (req.target_id),
        .in_adv_cost  (req.advertised_cost),
        .in_link_cost (req.link_cost),
        .res_status   (rsp.status),
        .res_hop      (rsp.next_hop),
        .res_cost     (rsp.route_cost),
        .res_req      (rsp.advert_request),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    // Entries beyond the fill count are never compared, so the RAM needs no reset.
    dvrt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_route_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

@@ rtl/core/dvrt_ram.sv @@
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/core/dvrt_ctrl.sv @@
module dvrt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  dvrt_pkg::dp_stat_t stat,
    output dvrt_pkg::dp_cmd_t  cmd
);
    import dvrt_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The result register may be reloaded when it is empty or being drained.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.load    = in_valid && in_ready;
    assign cmd.scan    = (state_reg == S_SCAN);
    assign cmd.resolve = (state_reg == S_RESOLVE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit || stat.miss)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.resolve)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

@@ rtl/core/dvrt_datapath.sv @@
module dvrt_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int NODE_W      = 16,
    parameter int COST_W      = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dvrt_pkg::dp_cmd_t                cmd,
    output dvrt_pkg::dp_stat_t               stat,
    input  logic                             cfg_we,
    input  logic [dvrt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [NODE_W-1:0]                cfg_wdata,
    input  logic [1:0]                       in_mode,
    input  logic [NODE_W-1:0]                in_neighbor,
    input  logic [NODE_W-1:0]                in_target,
    input  logic [COST_W-1:0]                in_adv_cost,
    input  logic [COST_W-1:0]                in_link_cost,
    output logic [dvrt_pkg::STATUS_W-1:0]    res_status,
    output logic [NODE_W-1:0]                res_hop,
    output logic [COST_W-1:0]                res_cost,
    output logic                             res_req,
    output logic                             ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]   ram_waddr,
    output logic [2*NODE_W+COST_W-1:0]       ram_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0]   ram_raddr,
    input  logic [2*NODE_W+COST_W-1:0]       ram_rdata
);
    import dvrt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int RAM_W = 2 * NODE_W + COST_W;

    // Configuration and entry zero, which lives in flops rather than the RAM.
    logic [NODE_W-1:0] own_id_reg;
    logic [NODE_W-1:0] bcast_reg;
    logic [NODE_W-1:0] e0_hop_reg;
    logic [NODE_W-1:0] e0_hop_next;
    logic [COST_W-1:0] e0_cost_reg;
    logic [COST_W-1:0] e0_cost_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // Request held for the duration of the search.
    logic [1:0]        mode_reg;
    logic [NODE_W-1:0] nbr_reg;
    logic [NODE_W-1:0] tgt_reg;
    logic [COST_W-1:0] newc_reg;
    logic [COST_W:0]   cost_sum;
    logic [COST_W-1:0] cost_sat;

    // Search pipeline: read address, then compare in the cycle after.
    logic [CNT_W-1:0]  rd_ptr_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              cmp_valid_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  found_idx_reg;
    logic [NODE_W-1:0] found_hop_reg;
    logic [COST_W-1:0] found_cost_reg;
    logic [NODE_W-1:0] cmp_dest;
    logic [NODE_W-1:0] cmp_hop;
    logic [COST_W-1:0] cmp_cost;
    logic              hit;
    logic              more;

    // Result register.
    logic [STATUS_W-1:0] res_status_reg;
    logic [NODE_W-1:0]   res_hop_reg;
    logic [COST_W-1:0]   res_cost_reg;
    logic                res_req_reg;

    // Resolve logic.
    logic                is_lookup;
    logic                better;
    logic                full;
    logic [STATUS_W-1:0] st_c;
    logic [NODE_W-1:0]   hop_c;
    logic [COST_W-1:0]   cost_c;
    logic                req_c;
    logic                ins_c;
    logic                upd_c;

    assign cost_sum = {1'b0, in_adv_cost} + {1'b0, in_link_cost};
    assign cost_sat = cost_sum[COST_W] ? {COST_W{1'b1}} : cost_sum[COST_W-1:0];

    assign cmp_dest = (cmp_idx_reg == '0) ? own_id_reg
                                          : ram_rdata[RAM_W-1 -: NODE_W];
    assign cmp_hop  = (cmp_idx_reg == '0) ? e0_hop_reg
                                          : ram_rdata[COST_W +: NODE_W];
    assign cmp_cost = (cmp_idx_reg == '0) ? e0_cost_reg
                                          : ram_rdata[COST_W-1:0];

    assign hit       = cmp_valid_reg && (cmp_dest == tgt_reg);
    assign more      = (rd_ptr_reg < count_reg);
    assign stat.hit  = hit;
    assign stat.miss = !cmp_valid_reg && !more;
    assign ram_raddr = rd_ptr_reg[IDX_W-1:0];

    assign is_lookup = (mode_reg != MODE_HELLO) && (mode_reg != MODE_DATA);
    assign better    = (found_cost_reg > newc_reg);
    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        st_c   = ST_UNCHANGED;
        hop_c  = '0;
        cost_c = '0;
        req_c  = 1'b0;
        ins_c  = 1'b0;
        upd_c  = 1'b0;
        if (is_lookup)
        begin
            if (tgt_reg == bcast_reg)
            begin
                st_c  = ST_FOUND;
                hop_c = bcast_reg;
            end
            else if (found_reg)
            begin
                st_c   = ST_FOUND;
                hop_c  = found_hop_reg;
                cost_c = found_cost_reg;
            end
            else
            begin
                st_c = ST_NOROUTE;
            end
        end
        else if (!found_reg)
        begin
            if (full)
            begin
                st_c = ST_FULL;
            end
            else
            begin
                st_c   = ST_INSERTED;
                hop_c  = nbr_reg;
                cost_c = newc_reg;
                ins_c  = 1'b1;
            end
        end
        else if ((mode_reg == MODE_DATA) && (found_hop_reg == nbr_reg))
        begin
            st_c   = ST_UPDATED;
            hop_c  = found_hop_reg;
            cost_c = newc_reg;
            upd_c  = 1'b1;
        end
        else if (better)
        begin
            st_c   = ST_UPDATED;
            hop_c  = nbr_reg;
            cost_c = newc_reg;
            req_c  = (mode_reg == MODE_HELLO);
            upd_c  = 1'b1;
        end
        else
        begin
            hop_c  = found_hop_reg;
            cost_c = found_cost_reg;
        end
    end

    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = found_idx_reg;
        ram_wdata    = {tgt_reg, hop_c, cost_c};
        e0_hop_next  = e0_hop_reg;
        e0_cost_next = e0_cost_reg;
        count_next   = count_reg;
        if (cmd.resolve)
        begin
            if (ins_c)
            begin
                ram_we     = 1'b1;
                ram_waddr  = count_reg[IDX_W-1:0];
                count_next = count_reg + 1'b1;
            end
            else if (upd_c)
            begin
                if (found_idx_reg == '0)
                begin
                    e0_hop_next  = hop_c;
                    e0_cost_next = cost_c;
                end
                else
                begin
                    ram_we = 1'b1;
                end
            end
        end
        else if (cfg_we && (cfg_index == REG_OWN_NODE_ID))
        begin
            e0_hop_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg    <= '0;
            bcast_reg     <= {NODE_W{1'b1}};
            e0_hop_reg    <= '0;
            e0_cost_reg   <= '0;
            count_reg     <= CNT_W'(1);
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            e0_hop_reg  <= e0_hop_next;
            e0_cost_reg <= e0_cost_next;
            count_reg   <= count_next;
            if (cfg_we && (cfg_index == REG_OWN_NODE_ID))
            begin
                own_id_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == REG_BROADCAST_ID))
            begin
                bcast_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                cmp_valid_reg <= 1'b1;
                found_reg     <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
                else
                begin
                    cmp_valid_reg <= more;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= in_mode;
            nbr_reg     <= in_neighbor;
            tgt_reg     <= in_target;
            newc_reg    <= cost_sat;
            rd_ptr_reg  <= CNT_W'(1);
            cmp_idx_reg <= '0;
        end
        else if (cmd.scan)
        begin
            if (hit)
            begin
                found_idx_reg  <= cmp_idx_reg;
                found_hop_reg  <= cmp_hop;
                found_cost_reg <= cmp_cost;
            end
            else if (more)
            begin
                cmp_idx_reg <= rd_ptr_reg[IDX_W-1:0];
                rd_ptr_reg  <= rd_ptr_reg + 1'b1;
            end
        end
        if (cmd.resolve)
        begin
            res_status_reg <= st_c;
            res_hop_reg    <= hop_c;
            res_cost_reg   <= cost_c;
            res_req_reg    <= req_c;
        end
    end

    assign res_status = res_status_reg;
    assign res_hop    = res_hop_reg;
    assign res_cost   = res_cost_reg;
    assign res_req    = res_req_reg;
endmodule

@@ rtl/core/dvrt_checker.sv @@
`include "distance_vector_route_table_assert.svh"

module dvrt_checker #(
    parameter int NODE_W = 16,
    parameter int COST_W = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [dvrt_pkg::STATUS_W-1:0] status,
    input logic [NODE_W-1:0]             next_hop,
    input logic [COST_W-1:0]             route_cost,
    input logic                          advert_request
);
    import dvrt_pkg::*;

    // A stalled response holds its contents.
    `DVRT_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(next_hop) && $stable(route_cost) && $stable(advert_request), "stalled response changed")

    // Only one request is in flight, so an accept closes the input in the next cycle.
    `DVRT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request accepted during search")

    // A re-advertisement is only requested together with an update.
    `DVRT_ASSERT_NOW(a_req_on_update, out_valid && advert_request, status == ST_UPDATED, "advert request without update")

    // Full table and missing route carry an empty route.
    `DVRT_ASSERT_NOW(a_empty_route, out_valid && (status == ST_FULL || status == ST_NOROUTE), next_hop == '0 && route_cost == '0 && !advert_request, "nonzero route on empty result")
endmodule

bind distance_vector_route_table dvrt_checker #(
    .NODE_W (NODE_ID_WIDTH),
    .COST_W (COST_WIDTH)
) u_dvrt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (req.valid),
    .in_ready       (req.ready),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .status         (rsp.status),
    .next_hop       (rsp.next_hop),
    .route_cost     (rsp.route_cost),
    .advert_request (rsp.advert_request)
);
